>>> hdl/hsr_pkg.sv
package hsr_pkg;

   // Fixed-point format: unsigned, FRAC_BITS fraction bits.
   localparam int FRAC_BITS = 24;
   localparam int VAL_W     = FRAC_BITS + 1;      // holds 0 .. ONE inclusive
   localparam int PROD_W    = VAL_W + FRAC_BITS;  // value times fraction

   localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

   // Field widths.
   localparam int HUE_W   = 9;
   localparam int SHADE_W = 10;
   localparam int CHAN_W  = 8;
   localparam int REM_W   = 6;                    // hue within a sector, 0 .. 59

   localparam int SHADE_MAX  = 1000;
   localparam int SHADE_HALF = 500;
   localparam int HUE_MAX    = 360;
   localparam int SECTOR_DEG = 60;

   // floor(s * ONE / 1000) = s * V_Q + floor(s * V_R / 1000).
   // The second term uses a reciprocal: floor(y / 1000) = (y * V_M) >> V_K,
   // exact for y below one million.
   localparam longint unsigned V_Q = ONE / 64'd1000;
   localparam longint unsigned V_R = ONE % 64'd1000;
   localparam int              V_K = 30;
   localparam longint unsigned V_M = ((64'd1 << V_K) + 64'd999) / 64'd1000;
   localparam longint unsigned V_C = V_R * V_M;
   localparam int              VC_W = SHADE_W + 31;

   // floor(rem * ONE / 60) = rem * F_Q + floor(rem * F_R / 60), same method.
   localparam longint unsigned F_Q = ONE / 64'd60;
   localparam longint unsigned F_R = ONE % 64'd60;
   localparam int              F_K = 18;
   localparam longint unsigned F_M = ((64'd1 << F_K) + 64'd59) / 64'd60;
   localparam longint unsigned F_C = F_R * F_M;
   localparam int              FC_W = REM_W + F_K;

   // Hue sectors of sixty degrees each.
   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

endpackage

>>> hdl/hue_shade_to_rgb_top.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_hue_degrees[8:0]
// rsp       out        rsp_valid / rsp_stall  rsp_red, rsp_green, rsp_blue [7:0]
// csr       in         csr_valid / csr_ready  csr_shade_level[9:0]
//
// A hue beat passes through a five-stage pipeline to the stage 5 output register.
// One beat is taken per clock while req_stall is low; the throughput is set by
// the pipeline, whose deepest stage holds one multiplier of value by fraction.
// Reset (synchronous, active high) empties every stage and sets the shade to 500.
// A stall on rsp holds the output register; upstream stages keep filling any
// empty slots, so req is only stalled once every stage holds a beat.
// The csr port is always ready; the shade register loads on each csr_valid beat.
module hue_shade_to_rgb_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hsr_pkg::HUE_W-1:0]    req_hue_degrees,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hsr_pkg::CHAN_W-1:0]   rsp_red,
   output logic [hsr_pkg::CHAN_W-1:0]   rsp_green,
   output logic [hsr_pkg::CHAN_W-1:0]   rsp_blue,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hsr_pkg::SHADE_W-1:0]  csr_shade_level
);

   localparam int F      = hsr_pkg::FRAC_BITS;
   localparam int VAL_W  = hsr_pkg::VAL_W;
   localparam int PROD_W = hsr_pkg::PROD_W;
   localparam int VC_W   = hsr_pkg::VC_W;
   localparam int FC_W   = hsr_pkg::FC_W;
   localparam int REM_W  = hsr_pkg::REM_W;
   localparam int HUE_W  = hsr_pkg::HUE_W;
   localparam int CHAN_W = hsr_pkg::CHAN_W;
   localparam int SC_W   = VAL_W + CHAN_W;   // x * 255 before the shift

   // ---------------------------------------------------------------------
   // Shade register.
   // ---------------------------------------------------------------------
   logic [hsr_pkg::SHADE_W-1:0] shade_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shade_ff <= hsr_pkg::SHADE_W'(hsr_pkg::SHADE_HALF);
      end else if (csr_valid && csr_ready) begin
         shade_ff <= csr_shade_level;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when the
   // stage after it is loading.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: sector split, shade saturation and the reciprocal products.
   // ---------------------------------------------------------------------
   logic [hsr_pkg::SHADE_W-1:0] s_sat;
   hsr_pkg::sector_type         sector1_in;
   logic [HUE_W-1:0]            base1;
   logic [HUE_W-1:0]            diff1;
   logic [REM_W-1:0]            rem1;
   logic                        bad1_in;

   logic [VAL_W-1:0]  vq1_in, vq1_ff;
   logic [VC_W-1:0]   vc1_in, vc1_ff;
   logic [F-1:0]      fq1_in, fq1_ff;
   logic [FC_W-1:0]   fc1_in, fc1_ff;
   hsr_pkg::sector_type sector1_ff;
   logic              bad1_ff;

   always_comb begin
      s_sat = (shade_ff > hsr_pkg::SHADE_W'(hsr_pkg::SHADE_MAX))
            ? hsr_pkg::SHADE_W'(hsr_pkg::SHADE_MAX) : shade_ff;
      bad1_in = (req_hue_degrees > HUE_W'(hsr_pkg::HUE_MAX));

      // Hue of exactly 360 folds back into the first sector with no fraction.
      priority if (req_hue_degrees < HUE_W'(1 * hsr_pkg::SECTOR_DEG)) begin
         sector1_in = hsr_pkg::SECTOR_0;
         base1      = '0;
      end else if (req_hue_degrees < HUE_W'(2 * hsr_pkg::SECTOR_DEG)) begin
         sector1_in = hsr_pkg::SECTOR_1;
         base1      = HUE_W'(1 * hsr_pkg::SECTOR_DEG);
      end else if (req_hue_degrees < HUE_W'(3 * hsr_pkg::SECTOR_DEG)) begin
         sector1_in = hsr_pkg::SECTOR_2;
         base1      = HUE_W'(2 * hsr_pkg::SECTOR_DEG);
      end else if (req_hue_degrees < HUE_W'(4 * hsr_pkg::SECTOR_DEG)) begin
         sector1_in = hsr_pkg::SECTOR_3;
         base1      = HUE_W'(3 * hsr_pkg::SECTOR_DEG);
      end else if (req_hue_degrees < HUE_W'(5 * hsr_pkg::SECTOR_DEG)) begin
         sector1_in = hsr_pkg::SECTOR_4;
         base1      = HUE_W'(4 * hsr_pkg::SECTOR_DEG);
      end else if (req_hue_degrees < HUE_W'(6 * hsr_pkg::SECTOR_DEG)) begin
         sector1_in = hsr_pkg::SECTOR_5;
         base1      = HUE_W'(5 * hsr_pkg::SECTOR_DEG);
      end else begin
         sector1_in = hsr_pkg::SECTOR_0;
         base1      = req_hue_degrees;
      end

      diff1 = req_hue_degrees - base1;
      rem1  = diff1[REM_W-1:0];

      vq1_in = VAL_W'(s_sat) * VAL_W'(hsr_pkg::V_Q);
      vc1_in = VC_W'(s_sat) * VC_W'(hsr_pkg::V_C);
      fq1_in = F'(rem1) * F'(hsr_pkg::F_Q);
      fc1_in = FC_W'(rem1) * FC_W'(hsr_pkg::F_C);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         vq1_ff     <= vq1_in;
         vc1_ff     <= vc1_in;
         fq1_ff     <= fq1_in;
         fc1_ff     <= fc1_in;
         sector1_ff <= sector1_in;
         bad1_ff    <= bad1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: value and fraction.
   // ---------------------------------------------------------------------
   logic [VAL_W-1:0] vsum2;
   logic [VAL_W-1:0] val2_in, val2_ff;
   logic [F-1:0]     frac2_in, frac2_ff;
   hsr_pkg::sector_type sector2_ff;
   logic             bad2_ff;

   always_comb begin
      vsum2    = vq1_ff + VAL_W'(vc1_ff >> hsr_pkg::V_K);
      val2_in  = VAL_W'(hsr_pkg::ONE) - vsum2;
      frac2_in = fq1_ff + F'(fc1_ff >> hsr_pkg::F_K);
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         val2_ff    <= val2_in;
         frac2_ff   <= frac2_in;
         sector2_ff <= sector1_ff;
         bad2_ff    <= bad1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: value times fraction.
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] prod3_in, prod3_ff;
   logic [VAL_W-1:0]  val3_ff;
   hsr_pkg::sector_type sector3_ff;
   logic              bad3_ff;

   assign prod3_in = PROD_W'(val2_ff) * PROD_W'(frac2_ff);

   always_ff @(posedge clock) begin
      if (rdy3) begin
         prod3_ff   <= prod3_in;
         val3_ff    <= val2_ff;
         sector3_ff <= sector2_ff;
         bad3_ff    <= bad2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: p, q, t and the sector mapping onto the three channels.
   // ---------------------------------------------------------------------
   logic [F-1:0]     half4;
   logic [F-1:0]     p4;
   logic [VAL_W-1:0] q4, t4;
   logic [VAL_W-1:0] r4_in, g4_in, b4_in;
   logic [VAL_W-1:0] r4_ff, g4_ff, b4_ff;
   logic             bad4_ff;

   always_comb begin
      half4 = prod3_ff[PROD_W-1:F+1];
      p4    = val3_ff[VAL_W-1:1];
      q4    = val3_ff - VAL_W'(half4);
      t4    = VAL_W'(p4) + VAL_W'(half4);

      unique case (sector3_ff)
         hsr_pkg::SECTOR_0: begin
            r4_in = val3_ff;     g4_in = t4;          b4_in = VAL_W'(p4);
         end
         hsr_pkg::SECTOR_1: begin
            r4_in = q4;          g4_in = val3_ff;     b4_in = VAL_W'(p4);
         end
         hsr_pkg::SECTOR_2: begin
            r4_in = VAL_W'(p4);  g4_in = val3_ff;     b4_in = t4;
         end
         hsr_pkg::SECTOR_3: begin
            r4_in = VAL_W'(p4);  g4_in = q4;          b4_in = val3_ff;
         end
         hsr_pkg::SECTOR_4: begin
            r4_in = t4;          g4_in = VAL_W'(p4);  b4_in = val3_ff;
         end
         default: begin
            r4_in = val3_ff;     g4_in = VAL_W'(p4);  b4_in = q4;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         r4_ff   <= r4_in;
         g4_ff   <= g4_in;
         b4_ff   <= b4_in;
         bad4_ff <= bad3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: scale by 255 (shift and subtract) and truncate to 8 bits.
   // An out-of-range hue gives black.
   // ---------------------------------------------------------------------
   logic [SC_W-1:0]   r5_sc, g5_sc, b5_sc;
   logic [CHAN_W-1:0] red5_in, green5_in, blue5_in;
   logic [CHAN_W-1:0] red5_ff, green5_ff, blue5_ff;

   always_comb begin
      r5_sc = {r4_ff, {CHAN_W{1'b0}}} - SC_W'(r4_ff);
      g5_sc = {g4_ff, {CHAN_W{1'b0}}} - SC_W'(g4_ff);
      b5_sc = {b4_ff, {CHAN_W{1'b0}}} - SC_W'(b4_ff);
      if (bad4_ff) begin
         red5_in   = '0;
         green5_in = '0;
         blue5_in  = '0;
      end else begin
         red5_in   = r5_sc[F+CHAN_W-1:F];
         green5_in = g5_sc[F+CHAN_W-1:F];
         blue5_in  = b5_sc[F+CHAN_W-1:F];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         red5_ff   <= red5_in;
         green5_ff <= green5_in;
         blue5_ff  <= blue5_in;
      end
   end

   assign rsp_red   = red5_ff;
   assign rsp_green = green5_ff;
   assign rsp_blue  = blue5_ff;

endmodule
